// ===== hw/rtl/qrs_pkg.sv =====
// Package for the quadratic root solver: field widths and root kind codes.
`default_nettype none

package qrs_pkg;

	localparam int IN_WIDTH    = 16;
	localparam int VALUE_WIDTH = 34;
	localparam int KIND_WIDTH  = 3;

	typedef enum logic [KIND_WIDTH-1:0] {
		KIND_ANY     = 3'd0,
		KIND_NONE    = 3'd1,
		KIND_LINEAR  = 3'd2,
		KIND_DOUBLE  = 3'd3,
		KIND_TWO     = 3'd4,
		KIND_COMPLEX = 3'd5
	} kind_t;

endpackage

`default_nettype wire

// ===== hw/rtl/qrs_if.sv =====
// Valid/ready channel interfaces for coefficient requests and root results.
`default_nettype none

interface qrs_in_if
	import qrs_pkg::*;
();
	logic                        valid;
	logic                        ready;
	logic signed [IN_WIDTH-1:0]  coef_a;
	logic signed [IN_WIDTH-1:0]  coef_b;
	logic signed [IN_WIDTH-1:0]  coef_c;

	modport source (output valid, coef_a, coef_b, coef_c, input ready);
	modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_out_if
	import qrs_pkg::*;
();
	logic                          valid;
	logic                          ready;
	kind_t                         root_kind;
	logic signed [VALUE_WIDTH-1:0] first_value;
	logic signed [VALUE_WIDTH-1:0] second_value;

	modport source (output valid, root_kind, first_value, second_value, input ready);
	modport sink   (input valid, root_kind, first_value, second_value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/qrs_sqrt_cell.sv =====
// One square root cell: settles one root bit from the next pair of radicand bits.
`default_nettype none

module qrs_sqrt_cell #(
	parameter int SW     = 33,
	parameter int SIDE_W = 51
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              vld_i,
	input  wire logic [2*SW-1:0]   x_i,
	input  wire logic [SW+1:0]     rem_i,
	input  wire logic [SW-1:0]     root_i,
	input  wire logic [SIDE_W-1:0] side_i,
	output logic                   vld_o,
	output logic [2*SW-1:0]        x_o,
	output logic [SW+1:0]          rem_o,
	output logic [SW-1:0]          root_o,
	output logic [SIDE_W-1:0]      side_o
);

	localparam int XW = 2 * SW;
	localparam int RW = SW + 2;

	logic [RW+1:0] rem_wide;
	logic [RW+1:0] trial;
	logic          fits;

	assign rem_wide = {rem_i, x_i[XW-1:XW-2]};
	assign trial    = (RW+2)'({root_i, 2'b01});
	assign fits     = rem_wide >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_o    <= {x_i[XW-3:0], 2'b00};
			rem_o  <= fits ? RW'(rem_wide - trial) : RW'(rem_wide);
			root_o <= {root_i[SW-2:0], fits};
			side_o <= side_i;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/qrs_div_cell.sv =====
// One divider cell: settles one quotient bit in each of the two division lanes.
`default_nettype none

module qrs_div_cell #(
	parameter int NW     = 34,
	parameter int DNW    = 17,
	parameter int SIDE_W = 5
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              vld_i,
	input  wire logic [NW-1:0]     num1_i,
	input  wire logic [NW-1:0]     num2_i,
	input  wire logic [DNW-1:0]    den1_i,
	input  wire logic [DNW-1:0]    den2_i,
	input  wire logic [DNW-1:0]    rem1_i,
	input  wire logic [DNW-1:0]    rem2_i,
	input  wire logic [NW-1:0]     quo1_i,
	input  wire logic [NW-1:0]     quo2_i,
	input  wire logic [SIDE_W-1:0] side_i,
	output logic                   vld_o,
	output logic [NW-1:0]          num1_o,
	output logic [NW-1:0]          num2_o,
	output logic [DNW-1:0]         den1_o,
	output logic [DNW-1:0]         den2_o,
	output logic [DNW-1:0]         rem1_o,
	output logic [DNW-1:0]         rem2_o,
	output logic [NW-1:0]          quo1_o,
	output logic [NW-1:0]          quo2_o,
	output logic [SIDE_W-1:0]      side_o
);

	logic [DNW:0] part1;
	logic [DNW:0] part2;
	logic         fit1;
	logic         fit2;

	assign part1 = {rem1_i, num1_i[NW-1]};
	assign part2 = {rem2_i, num2_i[NW-1]};
	assign fit1  = part1 >= {1'b0, den1_i};
	assign fit2  = part2 >= {1'b0, den2_i};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num1_o <= {num1_i[NW-2:0], 1'b0};
			num2_o <= {num2_i[NW-2:0], 1'b0};
			den1_o <= den1_i;
			den2_o <= den2_i;
			rem1_o <= fit1 ? DNW'(part1 - {1'b0, den1_i}) : DNW'(part1);
			rem2_o <= fit2 ? DNW'(part2 - {1'b0, den2_i}) : DNW'(part2);
			quo1_o <= {quo1_i[NW-2:0], fit1};
			quo2_o <= {quo2_i[NW-2:0], fit2};
			side_o <= side_i;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/quadratic_root_solver.sv =====
// Top level of the quadratic root solver: discriminant, square root and divider chains.
//
// channel  dir  handshake      payload
// coefs    in   valid/ready    coef_a, coef_b, coef_c (signed integers)
// roots    out  valid/ready    root_kind, first_value, second_value (Q fixed point)
//
// One request per cycle is accepted while no result is held; each result passes through
// these registered steps in order: multiply, discriminant, one square root cell per
// root bit, numerator set-up, magnitude, one divider cell per quotient bit, output.
// The whole pipeline holds while a result waits on roots.ready.
// arst_n clears the valid bits only; nothing else needs clearing.
`default_nettype none

module quadratic_root_solver
	import qrs_pkg::*;
#(
	parameter int COEF_WIDTH    = 16,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	qrs_in_if.sink    coefs,
	qrs_out_if.source roots
);

	localparam int W      = COEF_WIDTH;
	localparam int F      = FRACTION_BITS;
	localparam int SW     = W + F + 1;
	localparam int XW     = 2 * SW;
	localparam int DW     = 2 * W + 2;
	localparam int NW     = W + F + 2;
	localparam int DNW    = W + 1;
	localparam int SQ_SIDE = 3 * W + KIND_WIDTH;
	localparam int DV_SIDE = KIND_WIDTH + 2;
	localparam int QW     = NW + 1;
	localparam int EW     = (QW > VALUE_WIDTH) ? QW : VALUE_WIDTH;
	localparam logic signed [EW-1:0] VMAX = EW'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
	localparam logic signed [EW-1:0] VMIN = -VMAX - EW'(1);

	logic en;

	// coefficient fields at COEF_WIDTH
	logic signed [W-1:0] a_in, b_in, c_in;

	if (W <= IN_WIDTH) begin : g_narrow
		assign a_in = coefs.coef_a[W-1:0];
		assign b_in = coefs.coef_b[W-1:0];
		assign c_in = coefs.coef_c[W-1:0];
	end else begin : g_wide
		assign a_in = {{(W-IN_WIDTH){1'b0}}, coefs.coef_a};
		assign b_in = {{(W-IN_WIDTH){1'b0}}, coefs.coef_b};
		assign c_in = {{(W-IN_WIDTH){1'b0}}, coefs.coef_c};
	end

	logic [W-1:0] ma, mb, mc;

	assign ma = a_in[W-1] ? (~a_in + 1'b1) : a_in;
	assign mb = b_in[W-1] ? (~b_in + 1'b1) : b_in;
	assign mc = c_in[W-1] ? (~c_in + 1'b1) : c_in;

	// stage 1: products
	logic                vld_s1;
	logic signed [W-1:0] a_s1, b_s1, c_s1;
	logic [2*W-1:0]      pbb_s1, pac_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= coefs.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= a_in;
			b_s1   <= b_in;
			c_s1   <= c_in;
			pbb_s1 <= mb * mb;
			pac_s1 <= ma * mc;
		end
	end

	// stage 2: discriminant magnitude and kind
	logic [DW-1:0] bbx, ac4, dmag;
	logic          dneg;
	logic          opp;
	kind_t         kind_d;

	assign bbx = DW'(pbb_s1);
	assign ac4 = {pac_s1, 2'b00};
	assign opp = (c_s1 != '0) && (a_s1[W-1] != c_s1[W-1]);

	always_comb begin
		dneg = 1'b0;
		priority if (opp) begin
			dmag = bbx + ac4;
		end else if (bbx >= ac4) begin
			dmag = bbx - ac4;
		end else begin
			dmag = ac4 - bbx;
			dneg = 1'b1;
		end
	end

	always_comb begin
		priority if (a_s1 == '0 && b_s1 == '0 && c_s1 == '0) begin
			kind_d = KIND_ANY;
		end else if (a_s1 == '0 && b_s1 == '0) begin
			kind_d = KIND_NONE;
		end else if (a_s1 == '0) begin
			kind_d = KIND_LINEAR;
		end else if (dneg) begin
			kind_d = KIND_COMPLEX;
		end else if (dmag == '0) begin
			kind_d = KIND_DOUBLE;
		end else begin
			kind_d = KIND_TWO;
		end
	end

	logic               sq_vld  [SW+1];
	logic [XW-1:0]      sq_x    [SW+1];
	logic [SW+1:0]      sq_rem  [SW+1];
	logic [SW-1:0]      sq_root [SW+1];
	logic [SQ_SIDE-1:0] sq_side [SW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld[0] <= 1'b0;
		end else if (en) begin
			sq_vld[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_x[0]    <= {dmag, (2*F)'(0)};
			sq_rem[0]  <= '0;
			sq_root[0] <= '0;
			sq_side[0] <= {a_s1, b_s1, c_s1, kind_d};
		end
	end

	for (genvar i = 0; i < SW; i++) begin : g_sqrt
		qrs_sqrt_cell #(.SW(SW), .SIDE_W(SQ_SIDE)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (sq_vld[i]),
			.x_i    (sq_x[i]),
			.rem_i  (sq_rem[i]),
			.root_i (sq_root[i]),
			.side_i (sq_side[i]),
			.vld_o  (sq_vld[i+1]),
			.x_o    (sq_x[i+1]),
			.rem_o  (sq_rem[i+1]),
			.root_o (sq_root[i+1]),
			.side_o (sq_side[i+1])
		);
	end

	// stage 3: signed numerators and divisors
	logic signed [W-1:0] a_r, b_r, c_r;
	kind_t               kind_r;
	logic signed [NW:0]  bx, cx, sx, nb, nc;
	logic signed [W+1:0] ax2, bd, aabs2;
	logic signed [NW:0]  n1_d, n2_d;
	logic signed [W+1:0] d1_d, d2_d;

	assign {a_r, b_r, c_r} = sq_side[SW][SQ_SIDE-1:KIND_WIDTH];
	assign kind_r = kind_t'(sq_side[SW][KIND_WIDTH-1:0]);
	assign bx     = (NW+1)'(b_r);
	assign cx     = (NW+1)'(c_r);
	assign sx     = $signed((NW+1)'(sq_root[SW]));
	assign nb     = -(bx <<< F);
	assign nc     = -(cx <<< F);
	assign ax2    = (W+2)'(a_r) <<< 1;
	assign bd     = (W+2)'(b_r);
	assign aabs2  = a_r[W-1] ? -ax2 : ax2;

	always_comb begin
		n1_d = '0;
		n2_d = '0;
		d1_d = (W+2)'(1);
		d2_d = (W+2)'(1);
		unique case (kind_r)
			KIND_LINEAR: begin
				n1_d = nc;
				d1_d = bd;
			end
			KIND_DOUBLE: begin
				n1_d = nb;
				d1_d = ax2;
			end
			KIND_TWO: begin
				n1_d = nb - sx;
				n2_d = nb + sx;
				d1_d = ax2;
				d2_d = ax2;
			end
			KIND_COMPLEX: begin
				n1_d = nb;
				d1_d = ax2;
				n2_d = sx;
				d2_d = aabs2;
			end
			default: begin
			end
		endcase
	end

	logic                vld_s3;
	kind_t               kind_s3;
	logic signed [NW:0]  n1_s3, n2_s3;
	logic signed [W+1:0] d1_s3, d2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= sq_vld[SW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s3 <= kind_r;
			n1_s3   <= n1_d;
			n2_s3   <= n2_d;
			d1_s3   <= d1_d;
			d2_s3   <= d2_d;
		end
	end

	// stage 4: magnitudes into the divider chain
	logic [NW:0]  n1_abs, n2_abs;
	logic [W+1:0] d1_abs, d2_abs;

	assign n1_abs = n1_s3[NW] ? -n1_s3 : n1_s3;
	assign n2_abs = n2_s3[NW] ? -n2_s3 : n2_s3;
	assign d1_abs = d1_s3[W+1] ? -d1_s3 : d1_s3;
	assign d2_abs = d2_s3[W+1] ? -d2_s3 : d2_s3;

	logic               dv_vld  [NW+1];
	logic [NW-1:0]      dv_num1 [NW+1];
	logic [NW-1:0]      dv_num2 [NW+1];
	logic [DNW-1:0]     dv_den1 [NW+1];
	logic [DNW-1:0]     dv_den2 [NW+1];
	logic [DNW-1:0]     dv_rem1 [NW+1];
	logic [DNW-1:0]     dv_rem2 [NW+1];
	logic [NW-1:0]      dv_quo1 [NW+1];
	logic [NW-1:0]      dv_quo2 [NW+1];
	logic [DV_SIDE-1:0] dv_side [NW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld[0] <= 1'b0;
		end else if (en) begin
			dv_vld[0] <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_num1[0] <= n1_abs[NW-1:0];
			dv_num2[0] <= n2_abs[NW-1:0];
			dv_den1[0] <= d1_abs[DNW-1:0];
			dv_den2[0] <= d2_abs[DNW-1:0];
			dv_rem1[0] <= '0;
			dv_rem2[0] <= '0;
			dv_quo1[0] <= '0;
			dv_quo2[0] <= '0;
			dv_side[0] <= {kind_s3, n1_s3[NW] ^ d1_s3[W+1], n2_s3[NW] ^ d2_s3[W+1]};
		end
	end

	for (genvar j = 0; j < NW; j++) begin : g_div
		qrs_div_cell #(.NW(NW), .DNW(DNW), .SIDE_W(DV_SIDE)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (dv_vld[j]),
			.num1_i (dv_num1[j]),
			.num2_i (dv_num2[j]),
			.den1_i (dv_den1[j]),
			.den2_i (dv_den2[j]),
			.rem1_i (dv_rem1[j]),
			.rem2_i (dv_rem2[j]),
			.quo1_i (dv_quo1[j]),
			.quo2_i (dv_quo2[j]),
			.side_i (dv_side[j]),
			.vld_o  (dv_vld[j+1]),
			.num1_o (dv_num1[j+1]),
			.num2_o (dv_num2[j+1]),
			.den1_o (dv_den1[j+1]),
			.den2_o (dv_den2[j+1]),
			.rem1_o (dv_rem1[j+1]),
			.rem2_o (dv_rem2[j+1]),
			.quo1_o (dv_quo1[j+1]),
			.quo2_o (dv_quo2[j+1]),
			.side_o (dv_side[j+1])
		);
	end

	// output: apply signs and saturate
	logic              neg1, neg2;
	kind_t             kind_f;
	logic signed [QW-1:0] q1s, q2s;
	logic signed [EW-1:0] q1e, q2e;
	logic signed [EW-1:0] v1, v2;

	assign {kind_f, neg1, neg2} = {kind_t'(dv_side[NW][DV_SIDE-1:2]), dv_side[NW][1:0]};
	assign q1s = neg1 ? -$signed({1'b0, dv_quo1[NW]}) : $signed({1'b0, dv_quo1[NW]});
	assign q2s = neg2 ? -$signed({1'b0, dv_quo2[NW]}) : $signed({1'b0, dv_quo2[NW]});
	assign q1e = EW'(q1s);
	assign q2e = EW'(q2s);
	assign v1  = (q1e > VMAX) ? VMAX : ((q1e < VMIN) ? VMIN : q1e);
	assign v2  = (q2e > VMAX) ? VMAX : ((q2e < VMIN) ? VMIN : q2e);

	logic                          out_vld_q;
	kind_t                         kind_q;
	logic signed [VALUE_WIDTH-1:0] first_q, second_q;

	assign en = !out_vld_q || roots.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dv_vld[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_q   <= kind_f;
			first_q  <= v1[VALUE_WIDTH-1:0];
			second_q <= v2[VALUE_WIDTH-1:0];
		end
	end

	assign coefs.ready        = en;
	assign roots.valid        = out_vld_q;
	assign roots.root_kind    = kind_q;
	assign roots.first_value  = first_q;
	assign roots.second_value = second_q;

	// degenerate kinds carry no roots
	assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && (kind_q == KIND_ANY || kind_q == KIND_NONE)
		|-> first_q == '0 && second_q == '0)
		else $error("degenerate kind with non-zero value");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && (kind_q == KIND_LINEAR || kind_q == KIND_DOUBLE) |-> second_q == '0)
		else $error("single root kind with second value");

	// a held result must freeze the whole chain
	assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !roots.ready |=> $stable(dv_vld[NW]) && $stable(sq_vld[SW]))
		else $error("pipeline moved while result stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !roots.ready |-> !coefs.ready)
		else $error("request taken while result stalled");

endmodule

`default_nettype wire
